// ===== rtl/tvfpu_pkg.sv =====
// Shared types and constants for the TV-L1 primal update block.
`timescale 1ns / 1ps
`default_nettype none

package tvfpu_pkg;

	// Row store depth and the column index width that follows from it.
	localparam int MaxWidth = 1024;
	localparam int ColW = $clog2(MaxWidth);

	// Datapath widths.
	localparam int MsqW = 48;
	localparam int BaseW = 52;
	localparam int DvdW = 80;
	localparam int QuoW = 63;

	// Decoupling queue depth.
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);

	// Configuration register indexes.
	localparam logic [1:0] REG_LAM_THETA = 2'd0;
	localparam logic [1:0] REG_THETA_GAIN = 2'd1;
	localparam logic [1:0] REG_FRAME_WIDTH = 2'd2;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [30:0] lam_theta;
		logic [30:0] theta_gain;
		logic [10:0] frame_width;
		logic [15:0] frame_height;
	} cfg_t;

	// Per-pixel data that rides along the divider without change.
	typedef struct packed {
		logic signed [BaseW-1:0] base_u;
		logic signed [BaseW-1:0] base_v;
		logic proj;
		logic neg_u;
		logic neg_v;
		logic frame_end;
	} side_t;

	// One classified pixel passed from the front to the back.
	typedef struct packed {
		side_t side;
		logic [DvdW-1:0] dvd_u;
		logic [DvdW-1:0] dvd_v;
		logic [MsqW-1:0] msq;
	} item_t;

endpackage

`default_nettype wire

// ===== rtl/tvl1_flow_primal_update_top.sv =====
// Top level of the TV-L1 primal update: configuration registers, front, queue and back.
// Throughput: one pixel per cycle when nothing stalls; the 63-stage divider and the
// front multiplier stages are fully pipelined, and the four-entry queue lets front
// and back stall independently. Reset returns the configuration to its defaults and
// clears the raster counters, left duals and all valid flags at once; the row store
// of y duals is not cleared and needs no pass.
`timescale 1ns / 1ps
`default_nettype none

module tvl1_flow_primal_update_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [30:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] residual,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic signed [31:0] flow_u,
	input  logic signed [31:0] flow_v,
	input  logic signed [31:0] warp_u,
	input  logic signed [31:0] warp_v,
	input  logic signed [31:0] dual_ux,
	input  logic signed [31:0] dual_uy,
	input  logic signed [31:0] dual_vx,
	input  logic signed [31:0] dual_vy,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] new_u,
	output logic signed [31:0] new_v,
	output logic frame_end
);

	logic [30:0] lam_theta_q, theta_gain_q;
	logic [10:0] frame_width_q;
	logic [15:0] frame_height_q;
	tvfpu_pkg::cfg_t cfg;

	logic q_full, push, pop, q_nempty;
	tvfpu_pkg::item_t push_item, head_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_theta_q <= '0;
			theta_gain_q <= '0;
			frame_width_q <= 11'(tvfpu_pkg::MaxWidth);
			frame_height_q <= 16'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tvfpu_pkg::REG_LAM_THETA: lam_theta_q <= cfg_data;
				tvfpu_pkg::REG_THETA_GAIN: theta_gain_q <= cfg_data;
				tvfpu_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_data[10:0];
				tvfpu_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[15:0];
			endcase
		end
	end

	assign cfg.lam_theta = lam_theta_q;
	assign cfg.theta_gain = theta_gain_q;
	assign cfg.frame_width = frame_width_q;
	assign cfg.frame_height = frame_height_q;

	// Front: intake and classification.
	tvfpu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.residual(residual),
		.grad_x(grad_x),
		.grad_y(grad_y),
		.flow_u(flow_u),
		.flow_v(flow_v),
		.warp_u(warp_u),
		.warp_v(warp_v),
		.dual_ux(dual_ux),
		.dual_uy(dual_uy),
		.dual_vx(dual_vx),
		.dual_vy(dual_vy),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	// Decoupling queue.
	tvfpu_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.head_valid(q_nempty),
		.head_item(head_item)
	);

	// Back: division and output.
	tvfpu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(q_nempty),
		.head_item(head_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_u(new_u),
		.new_v(new_v),
		.frame_end(frame_end)
	);

`ifndef SYNTH
	// The back never takes a transaction from an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_nempty)
		else $error("queue popped while empty");

	// The front never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("queue pushed while full");

	// The queue only becomes full right after a push.
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(q_full) |-> $past(push))
		else $error("queue filled without a push");
`endif

endmodule

`default_nettype wire

// ===== rtl/tvfpu_front.sv =====
// Front part: pixel intake, raster counters, dual neighbors and threshold classification.
`timescale 1ns / 1ps
`default_nettype none

module tvfpu_front (
	input  logic clk,
	input  logic arst_n,
	input  tvfpu_pkg::cfg_t cfg,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] residual,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic signed [31:0] flow_u,
	input  logic signed [31:0] flow_v,
	input  logic signed [31:0] warp_u,
	input  logic signed [31:0] warp_v,
	input  logic signed [31:0] dual_ux,
	input  logic signed [31:0] dual_uy,
	input  logic signed [31:0] dual_vx,
	input  logic signed [31:0] dual_vy,
	input  logic q_full,
	output logic push,
	output tvfpu_pkg::item_t push_item
);

	logic adv, acc;
	logic [10:0] wlim;
	logic [15:0] hlim;
	logic last_col, last_row;

	logic [tvfpu_pkg::ColW-1:0] col_q;
	logic [15:0] row_q;
	logic signed [31:0] left_ux_q, left_vx_q;
	logic signed [31:0] row_uy_mem [tvfpu_pkg::MaxWidth];
	logic signed [31:0] row_vy_mem [tvfpu_pkg::MaxWidth];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// Stage 1
	logic signed [31:0] t_s1, gx_s1, gy_s1, u_s1, v_s1d, u0_s1, v0_s1;
	logic signed [31:0] pux_s1, puy_s1, pvx_s1, pvy_s1, lux_s1, lvx_s1;
	logic signed [31:0] up_uy_s1, up_vy_s1;
	logic has_left_s1, has_up_s1, fe_s1;

	// Stage 2
	logic signed [34:0] du_s2, dv_s2;
	logic signed [32:0] dfu_s2, dfv_s2;
	logic [31:0] agx_s2, agy_s2;
	logic sgx_s2, sgy_s2, fe_s2;
	logic signed [31:0] t_s2, u_s2, v_s2d;

	// Stage 3
	logic [32:0] adfu_s3, adfv_s3;
	logic sdfu_s3, sdfv_s3;
	logic [33:0] adu_s3, adv_s3;
	logic sdu_s3, sdv_s3;
	logic [63:0] sqx_s3, sqy_s3;
	logic [62:0] clx_s3, cly_s3;
	logic [31:0] agx_s3, agy_s3;
	logic sgx_s3, sgy_s3, fe_s3;
	logic signed [31:0] t_s3, u_s3, v_s3d;

	// Stage 4
	logic [64:0] pu_s4, pv_s4, dvu_s4, dvv_s4;
	logic pneg_u_s4, pneg_v_s4, dneg_u_s4, dneg_v_s4;
	logic [tvfpu_pkg::MsqW-1:0] msq_s4;
	logic [46:0] clu_s4, clv_s4;
	logic [31:0] agx_s4, agy_s4;
	logic sgx_s4, sgy_s4, fe_s4;
	logic signed [31:0] t_s4, u_s4, v_s4d;

	// Stage 5
	logic signed [49:0] rho_s5;
	logic [62:0] thr_hi_s5;
	logic [46:0] thr_lo_s5;
	logic signed [tvfpu_pkg::BaseW-1:0] bpu_s5, bpv_s5;
	logic [tvfpu_pkg::MsqW-1:0] msq_s5;
	logic [46:0] clu_s5, clv_s5;
	logic [31:0] agx_s5, agy_s5;
	logic sgx_s5, sgy_s5, fe_s5;

	// Stage 6
	logic [48:0] rmag_s6;
	logic srho_s6;
	logic [63:0] thr_s6;
	logic signed [tvfpu_pkg::BaseW-1:0] bpu_s6, bpv_s6, cu_s6, cv_s6;
	logic [tvfpu_pkg::MsqW-1:0] msq_s6;
	logic [31:0] agx_s6, agy_s6;
	logic sgx_s6, sgy_s6, fe_s6;

	// Stage 7
	logic signed [tvfpu_pkg::BaseW-1:0] base_u_s7, base_v_s7;
	logic proj_s7, neg_u_s7, neg_v_s7, fe_s7;
	logic [56:0] plo_u_s7, plo_v_s7;
	logic [55:0] phi_u_s7, phi_v_s7;
	logic [tvfpu_pkg::MsqW-1:0] msq_s7;

	// Stage 8
	tvfpu_pkg::item_t item_s8;

	// Combinational helpers
	logic [34:0] adu_c, adv_c;
	logic [47:0] msq_sum_c;
	logic signed [49:0] tu_c, tv_c, rho_c, rabs_c;
	logic signed [tvfpu_pkg::BaseW-1:0] dtu_c, dtv_c;
	logic big_c;

	// The front moves as a whole whenever the queue has room.
	assign adv = !q_full;
	assign in_stall = q_full;
	assign acc = in_valid && adv;
	assign push = v_s8 && adv;
	assign push_item = item_s8;

	// Effective frame size and raster position of the incoming pixel.
	always_comb begin
		if (cfg.frame_width == 11'd0) begin
			wlim = 11'd1;
		end else if (cfg.frame_width > 11'(tvfpu_pkg::MaxWidth)) begin
			wlim = 11'(tvfpu_pkg::MaxWidth);
		end else begin
			wlim = cfg.frame_width;
		end
		hlim = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;
		last_col = (11'(col_q) + 11'd1) >= wlim;
		last_row = (17'(row_q) + 17'd1) >= 17'(hlim);
	end

	// Raster counters and the left neighbor's x duals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			left_ux_q <= '0;
			left_vx_q <= '0;
		end else if (acc) begin
			left_ux_q <= dual_ux;
			left_vx_q <= dual_vx;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Row store of y duals: the old value is read as the new one is written.
	always_ff @(posedge clk) begin
		if (acc) begin
			row_uy_mem[col_q] <= dual_uy;
			row_vy_mem[col_q] <= dual_vy;
			up_uy_s1 <= row_uy_mem[col_q];
			up_vy_s1 <= row_vy_mem[col_q];
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (adv) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Stage 1 captures the pixel and its border flags.
	always_ff @(posedge clk) begin
		if (acc) begin
			t_s1 <= residual;
			gx_s1 <= grad_x;
			gy_s1 <= grad_y;
			u_s1 <= flow_u;
			v_s1d <= flow_v;
			u0_s1 <= warp_u;
			v0_s1 <= warp_v;
			pux_s1 <= dual_ux;
			puy_s1 <= dual_uy;
			pvx_s1 <= dual_vx;
			pvy_s1 <= dual_vy;
			lux_s1 <= left_ux_q;
			lvx_s1 <= left_vx_q;
			has_left_s1 <= (col_q != '0);
			has_up_s1 <= (row_q != 16'd0);
			fe_s1 <= last_col && last_row;
		end
	end

	// Magnitudes and arithmetic that only need registered operands.
	always_comb begin
		adu_c = du_s2[34] ? (~$unsigned(du_s2) + 35'd1) : $unsigned(du_s2);
		adv_c = dv_s2[34] ? (~$unsigned(dv_s2) + 35'd1) : $unsigned(dv_s2);
		msq_sum_c = sqx_s3[63:16] + sqy_s3[63:16];

		tu_c = $signed({1'b0, pu_s4[64:16]});
		tv_c = $signed({1'b0, pv_s4[64:16]});
		if (pneg_u_s4) begin
			tu_c = -tu_c;
		end
		if (pneg_v_s4) begin
			tv_c = -tv_c;
		end
		rho_c = 50'(t_s4) + tu_c + tv_c;
		dtu_c = $signed({3'b000, dvu_s4[64:16]});
		dtv_c = $signed({3'b000, dvv_s4[64:16]});
		if (dneg_u_s4) begin
			dtu_c = -dtu_c;
		end
		if (dneg_v_s4) begin
			dtv_c = -dtv_c;
		end

		rabs_c = rho_s5[49] ? -rho_s5 : rho_s5;
		big_c = 64'(rmag_s6) > thr_s6;
	end

	// Stages 2 to 8: linearised residual, threshold, class and dividend.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Divergence sums, flow offsets and gradient magnitudes.
			du_s2 <= 35'(pux_s1) + 35'(puy_s1)
				- (has_left_s1 ? 35'(lux_s1) : 35'sd0)
				- (has_up_s1 ? 35'(up_uy_s1) : 35'sd0);
			dv_s2 <= 35'(pvx_s1) + 35'(pvy_s1)
				- (has_left_s1 ? 35'(lvx_s1) : 35'sd0)
				- (has_up_s1 ? 35'(up_vy_s1) : 35'sd0);
			dfu_s2 <= 33'(u_s1) - 33'(u0_s1);
			dfv_s2 <= 33'(v_s1d) - 33'(v0_s1);
			agx_s2 <= gx_s1[31] ? (~$unsigned(gx_s1) + 32'd1) : $unsigned(gx_s1);
			agy_s2 <= gy_s1[31] ? (~$unsigned(gy_s1) + 32'd1) : $unsigned(gy_s1);
			sgx_s2 <= gx_s1[31];
			sgy_s2 <= gy_s1[31];
			t_s2 <= t_s1;
			u_s2 <= u_s1;
			v_s2d <= v_s1d;
			fe_s2 <= fe_s1;

			// Squares and clamp products of the gradient.
			adfu_s3 <= dfu_s2[32] ? (~$unsigned(dfu_s2) + 33'd1) : $unsigned(dfu_s2);
			adfv_s3 <= dfv_s2[32] ? (~$unsigned(dfv_s2) + 33'd1) : $unsigned(dfv_s2);
			sdfu_s3 <= dfu_s2[32];
			sdfv_s3 <= dfv_s2[32];
			adu_s3 <= adu_c[33:0];
			adv_s3 <= adv_c[33:0];
			sdu_s3 <= du_s2[34];
			sdv_s3 <= dv_s2[34];
			sqx_s3 <= agx_s2 * agx_s2;
			sqy_s3 <= agy_s2 * agy_s2;
			clx_s3 <= agx_s2 * cfg.lam_theta;
			cly_s3 <= agy_s2 * cfg.lam_theta;
			agx_s3 <= agx_s2;
			agy_s3 <= agy_s2;
			sgx_s3 <= sgx_s2;
			sgy_s3 <= sgy_s2;
			t_s3 <= t_s2;
			u_s3 <= u_s2;
			v_s3d <= v_s2d;
			fe_s3 <= fe_s2;

			// Residual and divergence products, squared magnitude.
			pu_s4 <= adfu_s3 * agx_s3;
			pv_s4 <= adfv_s3 * agy_s3;
			pneg_u_s4 <= sdfu_s3 ^ sgx_s3;
			pneg_v_s4 <= sdfv_s3 ^ sgy_s3;
			dvu_s4 <= adu_s3 * cfg.theta_gain;
			dvv_s4 <= adv_s3 * cfg.theta_gain;
			dneg_u_s4 <= sdu_s3;
			dneg_v_s4 <= sdv_s3;
			msq_s4 <= (msq_sum_c == '0) ? 48'd1 : msq_sum_c;
			clu_s4 <= clx_s3[62:16];
			clv_s4 <= cly_s3[62:16];
			agx_s4 <= agx_s3;
			agy_s4 <= agy_s3;
			sgx_s4 <= sgx_s3;
			sgy_s4 <= sgy_s3;
			t_s4 <= t_s3;
			u_s4 <= u_s3;
			v_s4d <= v_s3d;
			fe_s4 <= fe_s3;

			// Residual sum, threshold partial products, flow plus divergence.
			rho_s5 <= rho_c;
			thr_hi_s5 <= cfg.lam_theta * msq_s4[47:16];
			thr_lo_s5 <= cfg.lam_theta * msq_s4[15:0];
			bpu_s5 <= tvfpu_pkg::BaseW'(u_s4) + dtu_c;
			bpv_s5 <= tvfpu_pkg::BaseW'(v_s4d) + dtv_c;
			msq_s5 <= msq_s4;
			clu_s5 <= clu_s4;
			clv_s5 <= clv_s4;
			agx_s5 <= agx_s4;
			agy_s5 <= agy_s4;
			sgx_s5 <= sgx_s4;
			sgy_s5 <= sgy_s4;
			fe_s5 <= fe_s4;

			// Residual magnitude, full threshold and signed clamp steps.
			rmag_s6 <= rabs_c[48:0];
			srho_s6 <= rho_s5[49];
			thr_s6 <= 64'(thr_hi_s5) + 64'(thr_lo_s5[46:16]);
			cu_s6 <= sgx_s5 ? -$signed({5'b00000, clu_s5}) : $signed({5'b00000, clu_s5});
			cv_s6 <= sgy_s5 ? -$signed({5'b00000, clv_s5}) : $signed({5'b00000, clv_s5});
			bpu_s6 <= bpu_s5;
			bpv_s6 <= bpv_s5;
			msq_s6 <= msq_s5;
			agx_s6 <= agx_s5;
			agy_s6 <= agy_s5;
			sgx_s6 <= sgx_s5;
			sgy_s6 <= sgy_s5;
			fe_s6 <= fe_s5;

			// Classification: clamp one way, clamp the other, or project.
			if (big_c) begin
				base_u_s7 <= srho_s6 ? bpu_s6 + cu_s6 : bpu_s6 - cu_s6;
				base_v_s7 <= srho_s6 ? bpv_s6 + cv_s6 : bpv_s6 - cv_s6;
			end else begin
				base_u_s7 <= bpu_s6;
				base_v_s7 <= bpv_s6;
			end
			proj_s7 <= !big_c;
			neg_u_s7 <= srho_s6 ^ sgx_s6;
			neg_v_s7 <= srho_s6 ^ sgy_s6;
			plo_u_s7 <= rmag_s6[24:0] * agx_s6;
			plo_v_s7 <= rmag_s6[24:0] * agy_s6;
			phi_u_s7 <= rmag_s6[48:25] * agx_s6;
			phi_v_s7 <= rmag_s6[48:25] * agy_s6;
			msq_s7 <= msq_s6;
			fe_s7 <= fe_s6;

			// Full dividend for the projection quotient.
			item_s8.dvd_u <= 80'(plo_u_s7) + 80'({phi_u_s7, 25'd0});
			item_s8.dvd_v <= 80'(plo_v_s7) + 80'({phi_v_s7, 25'd0});
			item_s8.msq <= msq_s7;
			item_s8.side.base_u <= base_u_s7;
			item_s8.side.base_v <= base_v_s7;
			item_s8.side.proj <= proj_s7;
			item_s8.side.neg_u <= neg_u_s7;
			item_s8.side.neg_v <= neg_v_s7;
			item_s8.side.frame_end <= fe_s7;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tvfpu_fifo.sv =====
// Short queue that decouples the classifying front from the dividing back.
`timescale 1ns / 1ps
`default_nettype none

module tvfpu_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  tvfpu_pkg::item_t push_item,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output tvfpu_pkg::item_t head_item
);

	tvfpu_pkg::item_t slot_q [tvfpu_pkg::QDepth];
	logic [tvfpu_pkg::QPtrW-1:0] wr_q, rd_q;
	logic [tvfpu_pkg::QPtrW:0] cnt_q;

	assign full = (cnt_q == (tvfpu_pkg::QPtrW+1)'(tvfpu_pkg::QDepth));
	assign head_valid = (cnt_q != '0);
	assign head_item = slot_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tvfpu_back.sv =====
// Back part: pipelined restoring divider, final combine and saturating output register.
`timescale 1ns / 1ps
`default_nettype none

module tvfpu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  tvfpu_pkg::item_t head_item,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] new_u,
	output logic signed [31:0] new_v,
	output logic frame_end
);

	localparam int NStep = tvfpu_pkg::QuoW;
	localparam int MsqW = tvfpu_pkg::MsqW;

	logic adv;
	logic [NStep:0] vld_s;
	logic [MsqW-1:0] rem_u_s [NStep];
	logic [MsqW-1:0] rem_v_s [NStep];
	logic [MsqW-1:0] msq_s [NStep];
	logic [NStep-1:0] sh_u_s [NStep+1];
	logic [NStep-1:0] sh_v_s [NStep+1];
	tvfpu_pkg::side_t side_s [NStep+1];

	logic signed [65:0] qu_c, qv_c, sum_u_c, sum_v_c;
	logic ovld_q;
	logic signed [31:0] new_u_q, new_v_q;
	logic fe_q;

	// Saturate a wide signed value to 32 bits.
	function automatic logic [31:0] sat32(input logic signed [65:0] x);
		logic [31:0] r;
		if ((x[65:31] == '0) || (x[65:31] == '1)) begin
			r = x[31:0];
		end else if (x[65]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

	// The back moves whenever the output register is free or being taken.
	assign adv = !ovld_q || !out_stall;
	assign pop = adv && head_valid;

	assign out_valid = ovld_q;
	assign new_u = new_u_q;
	assign new_v = new_v_q;
	assign frame_end = fe_q;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NStep-1:0], head_valid};
		end
	end

	// Divider load: the top dividend bits form the first partial remainder.
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_u_s[0] <= MsqW'(head_item.dvd_u[tvfpu_pkg::DvdW-1:NStep]);
			rem_v_s[0] <= MsqW'(head_item.dvd_v[tvfpu_pkg::DvdW-1:NStep]);
			sh_u_s[0] <= head_item.dvd_u[NStep-1:0];
			sh_v_s[0] <= head_item.dvd_v[NStep-1:0];
			msq_s[0] <= head_item.msq;
			side_s[0] <= head_item.side;
		end
	end

	// One quotient bit per stage for each component.
	for (genvar k = 1; k <= NStep; k++) begin : g_step
		logic [MsqW:0] tu_w, tv_w, dd_w;
		logic ge_u, ge_v;

		assign dd_w = {1'b0, msq_s[k-1]};
		assign tu_w = {rem_u_s[k-1], sh_u_s[k-1][NStep-1]};
		assign tv_w = {rem_v_s[k-1], sh_v_s[k-1][NStep-1]};
		assign ge_u = (tu_w >= dd_w);
		assign ge_v = (tv_w >= dd_w);

		always_ff @(posedge clk) begin
			if (adv) begin
				sh_u_s[k] <= {sh_u_s[k-1][NStep-2:0], ge_u};
				sh_v_s[k] <= {sh_v_s[k-1][NStep-2:0], ge_v};
				side_s[k] <= side_s[k-1];
			end
		end

		if (k < NStep) begin : g_rem
			logic [MsqW:0] du_w, dv_w;

			assign du_w = tu_w - dd_w;
			assign dv_w = tv_w - dd_w;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_u_s[k] <= ge_u ? du_w[MsqW-1:0] : tu_w[MsqW-1:0];
					rem_v_s[k] <= ge_v ? dv_w[MsqW-1:0] : tv_w[MsqW-1:0];
					msq_s[k] <= msq_s[k-1];
				end
			end
		end
	end

	// Apply the signed projection step where the pixel was not clamped.
	always_comb begin
		qu_c = $signed({3'b000, sh_u_s[NStep]});
		qv_c = $signed({3'b000, sh_v_s[NStep]});
		sum_u_c = 66'(side_s[NStep].base_u);
		sum_v_c = 66'(side_s[NStep].base_v);
		if (side_s[NStep].proj) begin
			sum_u_c = side_s[NStep].neg_u ? sum_u_c + qu_c : sum_u_c - qu_c;
			sum_v_c = side_s[NStep].neg_v ? sum_v_c + qv_c : sum_v_c - qv_c;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv) begin
			ovld_q <= vld_s[NStep];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			new_u_q <= sat32(sum_u_c);
			new_v_q <= sat32(sum_v_c);
			fe_q <= side_s[NStep].frame_end;
		end
	end

endmodule

`default_nettype wire

// ===== dv/primal_update_checker.sv =====
// Checker for the TV-L1 primal update: watches both channels, predicts and compares.
`timescale 1ns / 1ps
`default_nettype none

module primal_update_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [30:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [31:0] residual,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic signed [31:0] flow_u,
	input  logic signed [31:0] flow_v,
	input  logic signed [31:0] warp_u,
	input  logic signed [31:0] warp_v,
	input  logic signed [31:0] dual_ux,
	input  logic signed [31:0] dual_uy,
	input  logic signed [31:0] dual_vx,
	input  logic signed [31:0] dual_vy,
	input  logic out_valid,
	input  logic out_stall,
	input  logic signed [31:0] new_u,
	input  logic signed [31:0] new_v,
	input  logic frame_end,
	output int errors,
	output int pending
);

	typedef logic signed [127:0] wide_t;
	typedef logic [127:0] uwide_t;

	typedef struct {
		logic signed [31:0] u;
		logic signed [31:0] v;
		logic last;
	} flow_res_t;

	// Copy of the configuration and the raster state of the block.
	logic [30:0] lam_theta;
	logic [30:0] theta_gain;
	logic [10:0] frame_width;
	logic [15:0] frame_height;
	wide_t prev_dual_ux;
	wide_t prev_dual_vx;
	wide_t line_dual_uy [tvfpu_pkg::MaxWidth];
	wide_t line_dual_vy [tvfpu_pkg::MaxWidth];
	int unsigned col_cnt;
	int unsigned row_cnt;
	flow_res_t expected_flow_q[$];

	initial begin
		errors = 0;
		for (int i = 0; i < tvfpu_pkg::MaxWidth; i++) begin
			line_dual_uy[i] = '0;
			line_dual_vy[i] = '0;
		end
	end

	assign pending = expected_flow_q.size();

	function automatic uwide_t absw(input wide_t a);
		return (a < 0) ? uwide_t'(-a) : uwide_t'(a);
	endfunction

	// Q16.16 product, truncated toward zero.
	function automatic wide_t qmul(input wide_t a, input wide_t b);
		uwide_t p;
		p = (absw(a) * absw(b)) >> 16;
		return ((a < 0) != (b < 0)) ? -wide_t'(p) : wide_t'(p);
	endfunction

	function automatic wide_t sat32(input wide_t a);
		if (a > 64'sd2147483647)
			return 64'sd2147483647;
		if (a < -64'sd2147483648)
			return -64'sd2147483648;
		return a;
	endfunction

	task automatic report(input string what, input logic signed [31:0] want,
			input logic signed [31:0] got);
		$display("%0t: %s differs: expected %0d, got %0d", $time, what, want, got);
		errors++;
	endtask

	// Works out the flow update of one pixel and advances the raster state.
	task automatic predict_flow();
		wide_t t, gx, gy, u, v, u0, v0, pux, puy, pvx, pvy;
		wide_t rho, nu, nv, du, dv, su, sv, lam, gain;
		uwide_t msq, thr, rmag, w, h;
		int unsigned col;
		logic last_col, last_row;
		flow_res_t r;
		t = residual; gx = grad_x; gy = grad_y;
		u = flow_u; v = flow_v; u0 = warp_u; v0 = warp_v;
		pux = dual_ux; puy = dual_uy; pvx = dual_vx; pvy = dual_vy;
		lam = wide_t'(lam_theta);
		gain = wide_t'(theta_gain);
		w = (frame_width == 0) ? 1 : frame_width;
		if (w > tvfpu_pkg::MaxWidth)
			w = tvfpu_pkg::MaxWidth;
		h = (frame_height == 0) ? 1 : frame_height;
		col = col_cnt % tvfpu_pkg::MaxWidth;

		// Linearised residual and threshold against the gradient magnitude.
		rho = t + qmul(u - u0, gx) + qmul(v - v0, gy);
		msq = ((absw(gx) * absw(gx)) >> 16) + ((absw(gy) * absw(gy)) >> 16);
		if (msq == 0)
			msq = 1;
		thr = uwide_t'(lam_theta) * (msq >> 16)
			+ ((uwide_t'(lam_theta) * (msq & 128'hFFFF)) >> 16);
		rmag = absw(rho);

		// Three-way thresholding step.
		nu = u;
		nv = v;
		if (rho < 0 && rmag > thr) begin
			nu += qmul(gx, lam);
			nv += qmul(gy, lam);
		end else if (rho > 0 && rmag > thr) begin
			nu -= qmul(gx, lam);
			nv -= qmul(gy, lam);
		end else begin
			su = wide_t'((rmag * absw(gx)) / msq);
			sv = wide_t'((rmag * absw(gy)) / msq);
			nu -= ((rho < 0) != (gx < 0)) ? -su : su;
			nv -= ((rho < 0) != (gy < 0)) ? -sv : sv;
		end

		// Backward divergence, with missing neighbors dropped at the borders.
		du = pux + puy;
		dv = pvx + pvy;
		if (col_cnt > 0) begin
			du -= prev_dual_ux;
			dv -= prev_dual_vx;
		end
		if (row_cnt > 0) begin
			du -= line_dual_uy[col];
			dv -= line_dual_vy[col];
		end
		r.u = 32'(sat32(nu + qmul(du, gain)));
		r.v = 32'(sat32(nv + qmul(dv, gain)));

		prev_dual_ux = pux;
		prev_dual_vx = pvx;
		line_dual_uy[col] = puy;
		line_dual_vy[col] = pvy;

		last_col = (col_cnt + 1 >= w);
		last_row = (row_cnt + 1 >= h);
		if (last_col) begin
			col_cnt = 0;
			row_cnt = last_row ? 0 : row_cnt + 1;
		end else begin
			col_cnt++;
		end
		r.last = last_col && last_row;
		expected_flow_q.push_back(r);
	endtask

	// Pixel transactions are predicted before a write at the same edge takes effect.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_theta = '0;
			theta_gain = '0;
			frame_width = 11'd1024;
			frame_height = 16'd1;
			prev_dual_ux = '0;
			prev_dual_vx = '0;
			col_cnt = 0;
			row_cnt = 0;
			expected_flow_q.delete();
		end else begin
			if (in_valid && !in_stall)
				predict_flow();
			if (cfg_write) begin
				case (cfg_index)
					tvfpu_pkg::REG_LAM_THETA: lam_theta = cfg_data;
					tvfpu_pkg::REG_THETA_GAIN: theta_gain = cfg_data;
					tvfpu_pkg::REG_FRAME_WIDTH: frame_width = cfg_data[10:0];
					tvfpu_pkg::REG_FRAME_HEIGHT: frame_height = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	// Result transactions are compared with the oldest prediction.
	always @(posedge clk) begin
		flow_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_flow_q.size() == 0) begin
				$display("%0t: result with no pixel waiting for it", $time);
				errors++;
			end else begin
				e = expected_flow_q.pop_front();
				if (new_u !== e.u)
					report("new_u", e.u, new_u);
				if (new_v !== e.v)
					report("new_v", e.v, new_v);
				if (frame_end !== e.last)
					report("frame_end", 32'(e.last), 32'(frame_end));
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/tb_tvl1_flow_primal_update_top.sv =====
// Testbench top for the TV-L1 primal update: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_tvl1_flow_primal_update_top;

	typedef struct packed {
		logic signed [31:0] residual;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic signed [31:0] flow_u;
		logic signed [31:0] flow_v;
		logic signed [31:0] warp_u;
		logic signed [31:0] warp_v;
		logic signed [31:0] dual_ux;
		logic signed [31:0] dual_uy;
		logic signed [31:0] dual_vx;
		logic signed [31:0] dual_vy;
	} pixel_t;

	localparam int StallLimit = 50000;
	localparam int DrainCycles = 100;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [30:0] cfg_data;
	logic in_valid;
	logic in_stall;
	pixel_t pix;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] new_u;
	logic signed [31:0] new_v;
	logic frame_end;
	int errors;
	int pending;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	tvl1_flow_primal_update_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.residual(pix.residual), .grad_x(pix.grad_x), .grad_y(pix.grad_y),
		.flow_u(pix.flow_u), .flow_v(pix.flow_v), .warp_u(pix.warp_u), .warp_v(pix.warp_v),
		.dual_ux(pix.dual_ux), .dual_uy(pix.dual_uy),
		.dual_vx(pix.dual_vx), .dual_vy(pix.dual_vy),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_u(new_u), .new_v(new_v), .frame_end(frame_end)
	);

	primal_update_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.residual(pix.residual), .grad_x(pix.grad_x), .grad_y(pix.grad_y),
		.flow_u(pix.flow_u), .flow_v(pix.flow_v), .warp_u(pix.warp_u), .warp_v(pix.warp_v),
		.dual_ux(pix.dual_ux), .dual_uy(pix.dual_uy),
		.dual_vx(pix.dual_vx), .dual_vy(pix.dual_vy),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_u(new_u), .new_v(new_v), .frame_end(frame_end),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at the rate of the current phase.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	// Watchdog on cycles that carry no transaction on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("tvl1_flow_primal_update_top: mismatch");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_value(input int spread);
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(2 * spread)) - spread;
		endcase
	endfunction

	// Mostly plausible flow data, with some fully random pixels mixed in.
	function automatic pixel_t random_pixel();
		pixel_t p;
		if ($urandom_range(9) < 2) begin
			p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
		end else begin
			p.residual = pick_value(1 << 18);
			p.grad_x = pick_value(1 << 18);
			p.grad_y = pick_value(1 << 18);
			p.flow_u = pick_value(1 << 20);
			p.flow_v = pick_value(1 << 20);
			p.warp_u = pick_value(1 << 20);
			p.warp_v = pick_value(1 << 20);
			p.dual_ux = pick_value(1 << 16);
			p.dual_uy = pick_value(1 << 16);
			p.dual_vx = pick_value(1 << 16);
			p.dual_vy = pick_value(1 << 16);
		end
		return p;
	endfunction

	// Drives one pixel transaction and holds it until it is taken.
	task automatic send_pixel(input pixel_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		pix <= p;
		in_valid <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input logic [30:0] lam, input logic [30:0] gain,
			input logic [10:0] width, input logic [15:0] height);
		wait_drained();
		write_reg(tvfpu_pkg::REG_LAM_THETA, lam);
		write_reg(tvfpu_pkg::REG_THETA_GAIN, gain);
		write_reg(tvfpu_pkg::REG_FRAME_WIDTH, 31'(width));
		write_reg(tvfpu_pkg::REG_FRAME_HEIGHT, 31'(height));
		@(negedge clk);
	endtask

	// Random pixels; halfway through, the sender holds off until all results are back.
	task automatic run_random(input int count, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained();
			send_pixel(random_pixel());
		end
		in_valid <= 1'b0;
	endtask

	// Border, saturation, zero-gradient and threshold cases at lam_theta of one.
	task automatic run_directed();
		pixel_t p;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		p = '0;
		send_pixel(p);
		send_pixel({11{32'sh7FFFFFFF}});
		send_pixel({11{32'sh80000000}});
		p = '0;
		p.residual = 32'sd123456;
		send_pixel(p);
		p.grad_x = 32'sd1;
		p.grad_y = -32'sd1;
		send_pixel(p);
		p = '0;
		p.grad_x = 32'sh00010000;
		p.residual = -32'sh000A0000;
		send_pixel(p);
		p.residual = 32'sh000A0000;
		send_pixel(p);
		p.residual = 32'sh00008000;
		send_pixel(p);
		p.residual = 32'sh00010000;
		send_pixel(p);
		p.grad_x = -32'sh00030000;
		p.grad_y = 32'sh00020000;
		p.residual = -32'sh00020000;
		p.flow_u = 32'sh00018000;
		p.warp_u = -32'sh00004000;
		send_pixel(p);
		p = '0;
		p.flow_u = 32'sh7FFFFFFF;
		p.flow_v = 32'sh80000000;
		p.dual_ux = 32'sh7FFFFFFF;
		p.dual_uy = 32'sh7FFFFFFF;
		p.dual_vx = 32'sh80000000;
		p.dual_vy = 32'sh80000000;
		send_pixel(p);
		p.dual_ux = 32'sh80000000;
		p.dual_uy = 32'sh80000000;
		p.dual_vx = 32'sh7FFFFFFF;
		p.dual_vy = 32'sh7FFFFFFF;
		send_pixel(p);
		for (int i = 0; i < 10; i++)
			send_pixel(random_pixel());
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = tvfpu_pkg::REG_LAM_THETA;
		cfg_data = '0;
		in_valid = 1'b0;
		pix = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// A first stretch of one row writes the row store columns that narrower frames read.
		run_random(64, 0, 0);
		set_config(31'd65536, 31'd16384, 11'd4, 16'd3);
		run_directed();
		run_random(60, 0, 0);
		set_config(31'h7FFFFFFF, 31'h7FFFFFFF, 11'd1, 16'd1);
		run_random(150, 77, 0);
		set_config(31'd0, 31'd0, 11'd1024, 16'd2);
		run_random(200, 0, 77);
		// Out-of-range width and zero height.
		set_config(31'd3277, 31'd8192, 11'd0, 16'd0);
		run_random(100, 12, 12);
		set_config(31'd20000, 31'd30000, 11'd2047, 16'd65535);
		run_random(150, 77, 0);
		set_config(31'd655, 31'd65536, 11'd17, 16'd5);
		run_random(150, 0, 77);
		// Shrinking mid-frame leaves the counters past the new end.
		set_config(31'd50000, 31'd1000, 11'd3, 16'd2);
		run_random(120, 0, 0);
		set_config(31'($urandom_range(200000)), 31'($urandom_range(100000)),
			11'($urandom_range(1, 64)), 16'($urandom_range(1, 8)));
		run_random(150, 12, 12);

		wait_drained();
		if (errors == 0 && pending == 0)
			$display("tvl1_flow_primal_update_top: match");
		else
			$display("tvl1_flow_primal_update_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
